// ===== src/mlxfp_pkg.sv =====
// Shared types and constants for the marker/length/XOR frame parser.
// Used by mlxfp_front, mlxfp_queue, mlxfp_back and the top level; no dependencies.
package mlxfp_pkg;

  // Frame markers and field codes
  localparam logic [7:0] START_FIRST  = 8'hA5;
  localparam logic [7:0] START_SECOND = 8'h5A;
  localparam logic [7:0] END_FIRST    = 8'h0D;
  localparam logic [7:0] END_SECOND   = 8'h0A;
  localparam logic [7:0] STOP_ACK     = 8'h01;

  localparam int unsigned MIN_LENGTH = 7;
  localparam int unsigned CAP_FIRST  = 4;   // first captured frame byte
  localparam int unsigned CAP_DEPTH  = 22;  // frame bytes 4..25
  localparam int unsigned CAP_IDX_W  = $clog2(CAP_DEPTH);

  // Queue between front and back
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QDEPTH = 1 << QPTR_W;
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADSUM = 2'd1,
    ST_BADEND = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PH_HUNT1 = 5'b00001,
    PH_HUNT2 = 5'b00010,
    PH_LENHI = 5'b00100,
    PH_LENLO = 5'b01000,
    PH_BODY  = 5'b10000
  } phase_e;

  // One classified byte, front to back
  typedef struct packed {
    logic                 clear;    // new frame: reset captures and checks
    logic                 do_xor;   // fold byte into running XOR
    logic                 do_sum;   // byte is the checksum
    logic                 do_end1;  // byte is the first end marker
    logic                 cap_en;   // store byte in capture slot
    logic [CAP_IDX_W-1:0] cap_slot;
    logic                 emit;     // last byte of frame: produce result
    logic                 bad_len;  // emit with bad-length status
    logic [7:0]           data;
    logic [15:0]          len;
  } op_t;

  typedef struct packed {
    status_e      status;
    logic [15:0]  frame_length;
    logic [7:0]   command_code;
    logic [15:0]  pc_word;
    logic [31:0]  epc_upper;
    logic [63:0]  epc_lower;
    logic [15:0]  rssi_negated;
    logic [7:0]   antenna_id;
    logic [23:0]  frequency_khz;
    logic [7:0]   phase_byte;
    logic         stop_acknowledged;
  } res_t;

  localparam int unsigned OUT_DATA_W = 200;  // 193 field bits padded to bytes

endpackage

// ===== src/mlxfp_front.sv =====
// Front end: hunts start markers, reads the length and classifies every byte.
// Depends on mlxfp_pkg.
module mlxfp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,   // byte accepted this cycle
  input  logic [7:0]         byte_i,
  output logic               push_o,
  output mlxfp_pkg::op_t     op_o
);

  mlxfp_pkg::phase_e phase_q, phase_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] len_q, len_d;
  logic        op_valid;
  logic [15:0] len_lo;
  logic [16:0] idx_ext, len_ext;

  assign len_lo  = {len_q[15:8], byte_i};
  assign idx_ext = {1'b0, idx_q};
  assign len_ext = {1'b0, len_q};

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    len_d    = len_q;
    op_valid = 1'b0;
    op_o     = '0;
    op_o.data = byte_i;
    op_o.len  = len_q;
    unique case (phase_q)
      mlxfp_pkg::PH_HUNT1: begin
        if (byte_i == mlxfp_pkg::START_FIRST) begin
          op_valid   = 1'b1;
          op_o.clear = 1'b1;
          phase_d    = mlxfp_pkg::PH_HUNT2;
        end
      end
      mlxfp_pkg::PH_HUNT2: begin
        if (byte_i == mlxfp_pkg::START_SECOND) begin
          phase_d = mlxfp_pkg::PH_LENHI;
        end else if (byte_i == mlxfp_pkg::START_FIRST) begin
          op_valid   = 1'b1;
          op_o.clear = 1'b1;
        end else begin
          phase_d = mlxfp_pkg::PH_HUNT1;
        end
      end
      mlxfp_pkg::PH_LENHI: begin
        len_d       = {byte_i, 8'h00};
        op_valid    = 1'b1;
        op_o.do_xor = 1'b1;
        phase_d     = mlxfp_pkg::PH_LENLO;
      end
      mlxfp_pkg::PH_LENLO: begin
        len_d       = len_lo;
        idx_d       = 16'(mlxfp_pkg::CAP_FIRST);
        op_valid    = 1'b1;
        op_o.do_xor = 1'b1;
        op_o.len    = len_lo;
        if (len_lo < 16'(mlxfp_pkg::MIN_LENGTH)) begin
          op_o.emit    = 1'b1;
          op_o.bad_len = 1'b1;
          phase_d      = mlxfp_pkg::PH_HUNT1;
        end else begin
          phase_d = mlxfp_pkg::PH_BODY;
        end
      end
      mlxfp_pkg::PH_BODY: begin
        op_valid      = 1'b1;
        op_o.cap_en   = idx_q < 16'(mlxfp_pkg::CAP_FIRST + mlxfp_pkg::CAP_DEPTH);
        op_o.cap_slot = mlxfp_pkg::CAP_IDX_W'(idx_q - 16'(mlxfp_pkg::CAP_FIRST));
        op_o.do_xor   = (idx_ext + 17'd4) <= len_ext;
        op_o.do_sum   = (idx_ext + 17'd3) == len_ext;
        op_o.do_end1  = (idx_ext + 17'd2) == len_ext;
        if ((idx_ext + 17'd1) >= len_ext) begin
          op_o.emit = 1'b1;
          phase_d   = mlxfp_pkg::PH_HUNT1;
        end else begin
          idx_d = idx_q + 16'd1;
        end
      end
      default: begin
        phase_d = mlxfp_pkg::PH_HUNT1;
      end
    endcase
  end

  assign push_o = fire_i && op_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mlxfp_pkg::PH_HUNT1;
      idx_q   <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

`ifndef ASSERT_OFF
  a_body_idx_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlxfp_pkg::PH_BODY |-> idx_q < len_q)
    else $error("byte index ran past frame length");
  a_body_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mlxfp_pkg::PH_BODY |-> len_q >= 16'(mlxfp_pkg::MIN_LENGTH))
    else $error("short frame entered body phase");
`endif

endmodule

// ===== src/mlxfp_queue.sv =====
// Small register FIFO of classified bytes between front and back.
// Depends on mlxfp_pkg.
module mlxfp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mlxfp_pkg::op_t   op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output mlxfp_pkg::op_t   op_o
);

  mlxfp_pkg::op_t mem_q [mlxfp_pkg::QDEPTH];
  logic [mlxfp_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [mlxfp_pkg::QCNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == mlxfp_pkg::QCNT_W'(mlxfp_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mlxfp_pkg::QCNT_W'(mlxfp_pkg::QDEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

// ===== src/mlxfp_back.sv =====
// Back end: captures inventory bytes, runs the XOR check, builds the result
// and holds it in the output register. Depends on mlxfp_pkg.
module mlxfp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mlxfp_pkg::op_t   op_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output mlxfp_pkg::res_t  res_o
);

  logic [7:0] cap_q [mlxfp_pkg::CAP_DEPTH];
  logic [7:0] cap_d [mlxfp_pkg::CAP_DEPTH];
  logic [7:0] xor_q;
  logic       sum_ok_q, end1_q;
  logic       out_free, valid_q;
  mlxfp_pkg::res_t res_q, res_d;
  logic [15:0] rssi_raw;

  assign out_free = !valid_q || res_ready_i;
  assign pop_o    = !empty_i && (!op_i.emit || out_free);

  always_comb begin
    for (int k = 0; k < mlxfp_pkg::CAP_DEPTH; k++) begin
      cap_d[k] = cap_q[k];
      if (op_i.clear) begin
        cap_d[k] = 8'h00;
      end else if (op_i.cap_en && op_i.cap_slot == mlxfp_pkg::CAP_IDX_W'(k)) begin
        cap_d[k] = op_i.data;
      end
    end
  end

  // Result fields come from the captures including the current byte
  assign rssi_raw = {cap_d[15], cap_d[16]};

  always_comb begin
    res_d = '0;
    if (op_i.bad_len) begin
      res_d.status = mlxfp_pkg::ST_BADLEN;
    end else if (!sum_ok_q) begin
      res_d.status = mlxfp_pkg::ST_BADSUM;
    end else if (!(end1_q && op_i.data == mlxfp_pkg::END_SECOND)) begin
      res_d.status = mlxfp_pkg::ST_BADEND;
    end else begin
      res_d.status = mlxfp_pkg::ST_OK;
    end
    res_d.frame_length      = op_i.len;
    res_d.command_code      = cap_d[0];
    res_d.pc_word           = {cap_d[1], cap_d[2]};
    res_d.epc_upper         = {cap_d[3], cap_d[4], cap_d[5], cap_d[6]};
    res_d.epc_lower         = {cap_d[7], cap_d[8], cap_d[9], cap_d[10],
                               cap_d[11], cap_d[12], cap_d[13], cap_d[14]};
    res_d.rssi_negated      = 16'h0000 - rssi_raw;
    res_d.antenna_id        = cap_d[17];
    res_d.frequency_khz     = {cap_d[18], cap_d[19], cap_d[20]};
    res_d.phase_byte        = cap_d[21];
    res_d.stop_acknowledged = cap_d[1] == mlxfp_pkg::STOP_ACK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mlxfp_pkg::CAP_DEPTH; k++) begin
        cap_q[k] <= 8'h00;
      end
      xor_q    <= '0;
      sum_ok_q <= 1'b0;
      end1_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        cap_q <= cap_d;
        if (op_i.clear) begin
          xor_q    <= '0;
          sum_ok_q <= 1'b0;
          end1_q   <= 1'b0;
        end else begin
          if (op_i.do_xor) begin
            xor_q <= xor_q ^ op_i.data;
          end
          if (op_i.do_sum) begin
            sum_ok_q <= op_i.data == xor_q;
          end
          if (op_i.do_end1) begin
            end1_q <= op_i.data == mlxfp_pkg::END_FIRST;
          end
        end
      end
      if (pop_o && op_i.emit) begin
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_badlen_no_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.status == mlxfp_pkg::ST_BADLEN |->
      res_q.command_code == 8'h00 && res_q.pc_word == 16'h0000)
    else $error("bad-length result carries captured bytes");
`endif

endmodule

// ===== src/marker_length_xor_frame_parser.sv =====
// Marker/length/XOR frame parser: one received byte per transfer in, one
// status-plus-inventory result per frame out. A byte can be taken every clock
// cycle, sustained, while the queue has room; the rate is set by the front
// end, which classifies each byte combinationally, and by the back end, which
// retires one classified byte per cycle while no result is stalled. A
// four-entry queue separates the two, and a result sits in a one-deep output
// register, so a stalled result stalls only the back end and input keeps
// flowing until the queue fills. A result becomes valid once its frame's last
// byte (or second length byte, for a bad length) has passed the queue and been
// registered by the back end. Frames start with A5 5A and a 16-bit big-endian
// total length; bytes 2 through length-4 are XORed and compared with byte
// length-3, and the frame must end in 0D 0A. Status: 0 ok, 1 bad checksum, 2
// bad end marker (checksum wins if both fail), 3 bad length (below 7, reported
// right after the length bytes with zero inventory fields). Inventory fields
// are taken from frame bytes 4..25; bytes past the frame end read as zero.
// Depends on mlxfp_pkg, mlxfp_front, mlxfp_queue and mlxfp_back.
module marker_length_xor_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // received byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  // frame results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] frame_length, [23:16] command_code, [39:24] pc_word,
  // [71:40] epc_upper, [135:72] epc_lower, [151:136] rssi_negated,
  // [159:152] antenna_id, [183:160] frequency_khz, [191:184] phase_byte,
  // [192] stop_acknowledged, [199:193] zero
  output logic [mlxfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] frame_status
);

  logic            in_fire;
  logic            q_full, q_empty, q_push, q_pop;
  mlxfp_pkg::op_t  front_op, back_op;
  mlxfp_pkg::res_t res;

  // Input transfer completes whenever the queue has room
  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  mlxfp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .byte_i (s_axis_tdata),
    .push_o (q_push),
    .op_o   (front_op)
  );

  mlxfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (back_op)
  );

  mlxfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .op_i        (back_op),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {7'b0,
                         res.stop_acknowledged,
                         res.phase_byte,
                         res.frequency_khz,
                         res.antenna_id,
                         res.rssi_negated,
                         res.epc_lower,
                         res.epc_upper,
                         res.pc_word,
                         res.command_code,
                         res.frame_length};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for marker_length_xor_frame_parser: streams bytes in,
// predicts every frame result, compares each result transfer field by field.
// Depends on mlxfp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module testbench;

  // Tracks the parser state byte by byte and keeps the frame results still owed.
  class frame_scoreboard;
    mlxfp_pkg::phase_e phase;
    int unsigned idx;       // index of the next frame byte
    logic [15:0] len;
    logic [7:0]  xsum;
    bit          sum_ok;
    bit          end1_ok;
    logic [7:0]  cap[mlxfp_pkg::CAP_DEPTH];
    mlxfp_pkg::res_t awaited[$];
    int          errors;
    int          frames_seen;

    function new();
      restart();
      phase = mlxfp_pkg::PH_HUNT1;
      errors = 0;
      frames_seen = 0;
    endfunction

    // First start byte seen: wipe the frame state and captures
    function void restart();
      phase = mlxfp_pkg::PH_HUNT2;
      idx = 0;
      len = '0;
      xsum = '0;
      sum_ok = 0;
      end1_ok = 0;
      foreach (cap[i]) cap[i] = 8'h00;
    endfunction

    function logic [7:0] fb(int unsigned n);
      return cap[n - mlxfp_pkg::CAP_FIRST];
    endfunction

    function void record(mlxfp_pkg::status_e st);
      mlxfp_pkg::res_t r;
      logic [15:0] rssi;
      rssi = {fb(19), fb(20)};
      r.status            = st;
      r.frame_length      = len;
      r.command_code      = fb(4);
      r.pc_word           = {fb(5), fb(6)};
      r.epc_upper         = {fb(7), fb(8), fb(9), fb(10)};
      r.epc_lower         = {fb(11), fb(12), fb(13), fb(14), fb(15), fb(16), fb(17), fb(18)};
      r.rssi_negated      = 16'h0000 - rssi;
      r.antenna_id        = fb(21);
      r.frequency_khz     = {fb(22), fb(23), fb(24)};
      r.phase_byte        = fb(25);
      r.stop_acknowledged = (fb(5) == mlxfp_pkg::STOP_ACK);
      awaited.push_back(r);
      frames_seen++;
    endfunction

    // One accepted input byte
    function void take_byte(logic [7:0] b);
      mlxfp_pkg::status_e st;
      case (phase)
        mlxfp_pkg::PH_HUNT1: begin
          if (b == mlxfp_pkg::START_FIRST) restart();
        end
        mlxfp_pkg::PH_HUNT2: begin
          if (b == mlxfp_pkg::START_SECOND) phase = mlxfp_pkg::PH_LENHI;
          else if (b == mlxfp_pkg::START_FIRST) restart();  // repeated A5 is a fresh first marker
          else phase = mlxfp_pkg::PH_HUNT1;
        end
        mlxfp_pkg::PH_LENHI: begin
          len = {b, 8'h00};
          xsum = b;
          phase = mlxfp_pkg::PH_LENLO;
        end
        mlxfp_pkg::PH_LENLO: begin
          len[7:0] = b;
          xsum ^= b;
          idx = mlxfp_pkg::CAP_FIRST;
          if (len < mlxfp_pkg::MIN_LENGTH) begin
            record(mlxfp_pkg::ST_BADLEN);  // reported right away, captures still zero
            phase = mlxfp_pkg::PH_HUNT1;
          end else begin
            phase = mlxfp_pkg::PH_BODY;
          end
        end
        mlxfp_pkg::PH_BODY: begin
          if (idx - mlxfp_pkg::CAP_FIRST < mlxfp_pkg::CAP_DEPTH) begin
            cap[idx - mlxfp_pkg::CAP_FIRST] = b;
          end
          if (idx + 4 <= len) xsum ^= b;
          else if (idx + 3 == len) sum_ok = (b == xsum);
          else if (idx + 2 == len) end1_ok = (b == mlxfp_pkg::END_FIRST);
          if (idx + 1 >= len) begin
            // checksum failure outranks a bad end marker
            if (!sum_ok) st = mlxfp_pkg::ST_BADSUM;
            else if (!(end1_ok && b == mlxfp_pkg::END_SECOND)) st = mlxfp_pkg::ST_BADEND;
            else st = mlxfp_pkg::ST_OK;
            record(st);
            phase = mlxfp_pkg::PH_HUNT1;
          end else begin
            idx++;
          end
        end
        default: phase = mlxfp_pkg::PH_HUNT1;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // One accepted result transfer
    function void check_result(logic [1:0] user, logic [mlxfp_pkg::OUT_DATA_W-1:0] data);
      mlxfp_pkg::res_t r;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected frame result, status %0d", user);
        return;
      end
      r = awaited.pop_front();
      compare_field("frame_status", r.status, user);
      compare_field("frame_length", r.frame_length, data[15:0]);
      compare_field("command_code", r.command_code, data[23:16]);
      compare_field("pc_word", r.pc_word, data[39:24]);
      compare_field("epc_upper", r.epc_upper, data[71:40]);
      compare_field("epc_lower", r.epc_lower, data[135:72]);
      compare_field("rssi_negated", r.rssi_negated, data[151:136]);
      compare_field("antenna_id", r.antenna_id, data[159:152]);
      compare_field("frequency_khz", r.frequency_khz, data[183:160]);
      compare_field("phase_byte", r.phase_byte, data[191:184]);
      compare_field("stop_acknowledged", r.stop_acknowledged, data[192]);
      compare_field("padding", '0, data[mlxfp_pkg::OUT_DATA_W-1:193]);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [mlxfp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  frame_scoreboard sb = new();

  int unsigned send_idle_pct = 0;   // chance, drawn anew after each idle, that the sender idles before a byte
  int unsigned recv_idle_pct = 0;   // chance per cycle that the receiver drops tready
  int unsigned recv_hold = 0;       // cycles of forced receiver back-pressure left
  int unsigned bytes_taken = 0;

  marker_length_xor_frame_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one byte, with random idle cycles ahead of it, until it is taken
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_taken++;
    sb.take_byte(b);
  endtask

  // A5 5A, length, body, checksum, end pair; lengths below seven stop after
  // the length bytes since the parser gives up there.
  task automatic send_frame(logic [15:0] flen, bit bad_sum, bit bad_end);
    logic [7:0] x;
    logic [7:0] b;
    logic [7:0] e1;
    logic [7:0] e2;
    send_byte(mlxfp_pkg::START_FIRST);
    send_byte(mlxfp_pkg::START_SECOND);
    send_byte(flen[15:8]);
    send_byte(flen[7:0]);
    if (flen < mlxfp_pkg::MIN_LENGTH) return;
    x = flen[15:8] ^ flen[7:0];
    for (int unsigned i = 4; i + 4 <= flen; i++) begin
      b = 8'($urandom_range(255));
      if (i == 5 && $urandom_range(3) == 0) b = mlxfp_pkg::STOP_ACK;
      x ^= b;
      send_byte(b);
    end
    if (bad_sum) x ^= 8'($urandom_range(1, 255));
    send_byte(x);
    e1 = mlxfp_pkg::END_FIRST;
    e2 = mlxfp_pkg::END_SECOND;
    if (bad_end) begin
      case ($urandom_range(2))
        0: e1 = mlxfp_pkg::END_FIRST ^ 8'($urandom_range(1, 255));
        1: e2 = mlxfp_pkg::END_SECOND ^ 8'($urandom_range(1, 255));
        default: begin
          e1 = mlxfp_pkg::END_SECOND;
          e2 = mlxfp_pkg::END_FIRST;
        end
      endcase
    end
    send_byte(e1);
    send_byte(e2);
  endtask

  // Mostly well-formed frames with random content; some noise, broken start
  // pairs, short lengths and corrupted checks mixed in.
  task automatic random_traffic(int unsigned until_bytes, int unsigned min_frames);
    int unsigned pick;
    logic [15:0] flen;
    logic [7:0]  b;
    while (bytes_taken < until_bytes || sb.frames_seen < min_frames) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(255));
          if (b == mlxfp_pkg::START_FIRST) b = 8'h00;  // keep noise from opening a frame
          send_byte(b);
        end
      end else if (pick < 35) begin
        b = 8'($urandom_range(255));
        if (b == mlxfp_pkg::START_SECOND) b = 8'hFF;
        send_byte(mlxfp_pkg::START_FIRST);
        send_byte(b);
      end
      pick = $urandom_range(99);
      if (pick < 15) flen = 16'($urandom_range(mlxfp_pkg::MIN_LENGTH - 1));
      else if (pick < 70) flen = 16'($urandom_range(7, 26));
      else if (pick < 95) flen = 16'($urandom_range(26, 40));
      else flen = 16'($urandom_range(100, 260));
      send_frame(flen, $urandom_range(9) == 0, $urandom_range(9) == 0);
    end
  endtask

  // Result side: check each transfer, then pick tready for the next cycle
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 47;

    // Directed: noise in hunt, broken start pair, repeated first marker with
    // length zero, longest bad length, minimal good frame, both checks failing.
    send_byte(8'hFF);
    send_byte(mlxfp_pkg::START_FIRST);
    send_byte(8'h00);
    send_byte(mlxfp_pkg::START_FIRST);
    send_byte(mlxfp_pkg::START_FIRST);
    send_byte(mlxfp_pkg::START_SECOND);
    send_byte(8'h00);
    send_byte(8'h00);
    send_frame(16'd6, 1'b0, 1'b0);
    send_frame(16'd7, 1'b0, 1'b0);
    send_frame(16'd7, 1'b1, 1'b1);

    random_traffic(bytes_taken + 200, 0);

    // Sender goes quiet until every owed result is out
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);

    send_idle_pct = 47;
    recv_idle_pct = 21;
    random_traffic(bytes_taken + 200, 0);

    // Full rate both ways, with one long receiver stall up front so the
    // output register and queue fill and the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 400;
    random_traffic(bytes_taken + 200, 48);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

endmodule
